/* rtl/core/rolling_window_mean_variance_assert.svh */
// ----------------------------------------------------------------------------
// Rolling window mean/variance assertion macros
// Implication checks on the top level clock and reset.
// ----------------------------------------------------------------------------
`ifndef ROLLING_WINDOW_MEAN_VARIANCE_ASSERT_SVH
`define ROLLING_WINDOW_MEAN_VARIANCE_ASSERT_SVH

// same-cycle implication
`define RWMV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rwmv: check failed");

// next-cycle implication
`define RWMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rwmv: check failed");

`endif

/* rtl/core/rwmv_pkg.sv */
// ----------------------------------------------------------------------------
// rwmv_pkg
// Shared types and constants of the rolling window mean/variance block.
// ----------------------------------------------------------------------------
package rwmv_pkg;

  localparam int DIFF_W    = 48;   // Q16 differences
  localparam int MEAN_W    = 34;
  localparam int SDS_W     = 62;
  localparam int NUM_W     = 64;   // divider numerator
  localparam int DEN_W     = 24;   // divider denominator
  localparam int RAD_W     = 48;
  localparam int ROOT_W    = 24;
  localparam int WL_W      = 11;
  localparam int OUT_W     = 168;  // 163 field bits padded to bytes
  localparam int DIV_STEPS = 64;
  localparam int SQ_STEPS  = 24;

  localparam logic [1:0] DSEL_MEAN = 2'd0;
  localparam logic [1:0] DSEL_VAR  = 2'd1;
  localparam logic [1:0] DSEL_Z    = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       mean_upd;
    logic       fac;
    logic       mul;
    logic       sds_upd;
    logic       drop;
    logic       var_ld;
    logic       var_clr;
    logic       sqrt_start;
    logic       z_ld;
    logic       z_clr;
    logic       out_ld;
  } rwmv_cmd_t;

  typedef struct packed {
    logic removing;
    logic second;
    logic var_ok;
    logic sd_nz;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } rwmv_stat_t;

endpackage

/* rtl/core/rwmv_div.sv */
// ----------------------------------------------------------------------------
// rwmv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwmv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rwmv_pkg::NUM_W-1:0] num,
  input  logic [rwmv_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [rwmv_pkg::NUM_W-1:0] quot
);
  import rwmv_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rs;
  logic             ge;

  assign rs = {rem, quot[NUM_W-1]};
  assign ge = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      rem  <= ge ? DEN_W'(rs - {1'b0, den_r}) : DEN_W'(rs);
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/rwmv_sqrt.sv */
// ----------------------------------------------------------------------------
// rwmv_sqrt
// Digit-by-digit integer square root, one root bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rwmv_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rwmv_pkg::RAD_W-1:0]  rad,
  output logic                        done,
  output logic [rwmv_pkg::ROOT_W-1:0] root
);
  import rwmv_pkg::*;

  localparam int CNT_W = $clog2(SQ_STEPS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem;     // stays below 2*root+1
  logic [ROOT_W+2:0] rs;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  assign rs    = {rem, rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rem   <= ge ? (ROOT_W+1)'(rs - trial) : (ROOT_W+1)'(rs);
      root  <= {root[ROOT_W-2:0], ge};
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
    end
  end

endmodule

/* rtl/core/rwmv_ctrl.sv */
// ----------------------------------------------------------------------------
// rwmv_ctrl
// Sequencer: add pass, optional removal pass, variance, root, z-score, output.
// ----------------------------------------------------------------------------
module rwmv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwmv_pkg::rwmv_stat_t st,
  output rwmv_pkg::rwmv_cmd_t  cmd
);
  import rwmv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MDIV  = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_FAC   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SDS   = 4'd5;
  localparam logic [3:0] S_DROP  = 4'd6;
  localparam logic [3:0] S_VARC  = 4'd7;
  localparam logic [3:0] S_VWAIT = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;
  localparam logic [3:0] S_SQW   = 4'd10;
  localparam logic [3:0] S_ZC    = 4'd11;
  localparam logic [3:0] S_ZWAIT = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MEAN;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (st.div_done) begin
          cmd.mean_upd = 1'b1;
          state_next   = S_FAC;
        end
      end
      S_FAC: begin
        cmd.fac    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SDS;
      end
      S_SDS: begin
        cmd.sds_upd = 1'b1;
        state_next  = (st.removing && !st.second) ? S_DROP : S_VARC;
      end
      S_DROP: begin
        cmd.drop   = 1'b1;
        state_next = S_MDIV;
      end
      S_VARC: begin
        if (st.var_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_VAR;
          state_next    = S_VWAIT;
        end else begin
          cmd.var_clr = 1'b1;
          state_next  = S_SQ;
        end
      end
      S_VWAIT: begin
        if (st.div_done) begin
          cmd.var_ld = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQW;
      end
      S_SQW: begin
        if (st.sqrt_done) state_next = S_ZC;
      end
      S_ZC: begin
        if (st.sd_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_Z;
          state_next    = S_ZWAIT;
        end else begin
          cmd.z_clr  = 1'b1;
          state_next = S_OUT;
        end
      end
      S_ZWAIT: begin
        if (st.div_done) begin
          cmd.z_ld   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

/* rtl/core/rwmv_dp.sv */
// ----------------------------------------------------------------------------
// rwmv_dp
// Sample ring, running sums, shared divider, root unit and result register.
// ----------------------------------------------------------------------------
module rwmv_dp #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rwmv_pkg::WL_W-1:0]   cfg_data,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  rwmv_pkg::rwmv_cmd_t         cmd,
  output rwmv_pkg::rwmv_stat_t        st,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rwmv_pkg::OUT_W-1:0]  out_data,
  output logic                        out_flag
);
  import rwmv_pkg::*;

  localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int CMPW = (CW > WL_W) ? CW : WL_W;
  localparam int SUMW = (SAMPLE_BITS + CW + 1 > 27) ? SAMPLE_BITS + CW + 1 : 27;
  localparam logic signed [SUMW-1:0]   SUM_HI  = SUMW'(33554431);
  localparam logic signed [SUMW-1:0]   SUM_LO  = SUMW'(-33554432);
  localparam logic signed [DIFF_W-1:0] MEAN_HI = DIFF_W'(64'sd8589934591);
  localparam logic signed [DIFF_W-1:0] MEAN_LO = DIFF_W'(-64'sd8589934592);
  localparam logic signed [NUM_W-1:0]  SDS_HI  = NUM_W'(64'sd2305843009213693951);
  localparam logic signed [NUM_W-1:0]  SDS_LO  = NUM_W'(-64'sd2305843009213693952);

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  logic [WL_W-1:0]               wl;
  logic [PW-1:0]                 wp;
  logic [CW-1:0]                 count;
  logic signed [SUMW-1:0]        sum;
  logic signed [MEAN_W-1:0]      mean;
  logic signed [MEAN_W-1:0]      prev;
  logic signed [SDS_W-1:0]       sds;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic                          removing;
  logic                          second;
  logic [31:0]                   ma;
  logic [31:0]                   mb;
  logic                          psign;
  logic [63:0]                   prod;
  logic [RAD_W-1:0]              var_r;
  logic [21:0]                   z_r;

  logic [CMPW-1:0]           wl_ext;
  logic [CMPW-1:0]           win;
  logic [CMPW-1:0]           cnt_ext;
  logic [CW:0]               oa_diff;
  logic [PW-1:0]             old_addr;
  logic signed [DIFF_W-1:0]  xq;
  logic signed [DIFF_W-1:0]  oq;
  logic signed [DIFF_W-1:0]  vq;
  logic signed [DIFF_W-1:0]  mean_x;
  logic signed [DIFF_W-1:0]  prev_x;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag;
  logic signed [DIFF_W-1:0]  dz;
  logic [DIFF_W-1:0]         magz;
  logic signed [DIFF_W-1:0]  fa;
  logic signed [DIFF_W-1:0]  fb;
  logic [DIFF_W-1:0]         mfa;
  logic [DIFF_W-1:0]         mfb;
  logic signed [DIFF_W-1:0]  sq;
  logic signed [DIFF_W-1:0]  mean_sum;
  logic signed [NUM_W-1:0]   term;
  logic signed [NUM_W-1:0]   sds_sum;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [NUM_W-1:0]          quot;
  logic                      div_done;
  logic [ROOT_W-1:0]         sd;
  logic                      sqrt_done;
  logic [25:0]               sum_out;
  logic [31:0]               mean_out;

  // effective window: zero acts as one, clamp at the ring depth
  assign wl_ext  = CMPW'(wl);
  assign cnt_ext = CMPW'(count);
  always_comb begin
    if (wl_ext == '0)                     win = CMPW'(1);
    else if (wl_ext > CMPW'(MAX_WINDOW)) win = CMPW'(MAX_WINDOW);
    else                                  win = wl_ext;
  end

  assign oa_diff  = (CW+1)'(wp) - (CW+1)'(count);
  assign old_addr = oa_diff[CW] ? PW'(oa_diff + (CW+1)'(MAX_WINDOW)) : PW'(oa_diff);

  assign xq     = {{(DIFF_W-SAMPLE_BITS-16){x_reg[SAMPLE_BITS-1]}}, x_reg, 16'b0};
  assign oq     = {{(DIFF_W-SAMPLE_BITS-16){old_q[SAMPLE_BITS-1]}}, old_q, 16'b0};
  assign vq     = second ? oq : xq;
  assign mean_x = DIFF_W'(mean);
  assign prev_x = DIFF_W'(prev);
  assign diff   = vq - mean_x;
  assign mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign dz     = xq - mean_x;
  assign magz   = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
  assign fa     = vq - mean_x;
  assign fb     = vq - prev_x;
  assign mfa    = fa[DIFF_W-1] ? DIFF_W'(-fa) : DIFF_W'(fa);
  assign mfb    = fb[DIFF_W-1] ? DIFF_W'(-fb) : DIFF_W'(fb);

  assign sq       = diff[DIFF_W-1] ? -$signed(quot[DIFF_W-1:0]) : $signed(quot[DIFF_W-1:0]);
  assign mean_sum = second ? mean_x - sq : mean_x + sq;

  assign term    = psign ? -$signed({16'b0, prod[63:16]}) : $signed({16'b0, prod[63:16]});
  assign sds_sum = second ? NUM_W'(sds) - term : NUM_W'(sds) + term;

  always_comb begin
    case (cmd.div_sel)
      DSEL_MEAN: begin
        div_num = NUM_W'(mag);
        div_den = DEN_W'(count);
      end
      DSEL_VAR: begin
        div_num = NUM_W'(unsigned'(sds));
        div_den = DEN_W'(count - 1'b1);
      end
      default: begin
        div_num = NUM_W'({magz, 8'b0});
        div_den = sd;
      end
    endcase
  end

  rwmv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  rwmv_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .rad   (var_r),
    .done  (sqrt_done),
    .root  (sd)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[wp] <= signed'(in_sample);
      old_q    <= ring[old_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wl        <= WL_W'(1024);
      wp        <= '0;
      count     <= '0;
      sum       <= '0;
      mean      <= '0;
      sds       <= '0;
      removing  <= 1'b0;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_ld)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        wl    <= cfg_data;
        wp    <= '0;
        count <= '0;
        sum   <= '0;
        mean  <= '0;
        sds   <= '0;
      end
      if (cmd.accept) begin
        removing <= (cnt_ext >= win);
        second   <= 1'b0;
        wp       <= (wp == PW'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
        count    <= count + 1'b1;
        sum      <= sum + SUMW'(signed'(in_sample));
      end
      if (cmd.drop) begin
        second <= 1'b1;
        count  <= count - 1'b1;
        sum    <= sum - SUMW'(old_q);
      end
      if (cmd.mean_upd) begin
        if (mean_sum > MEAN_HI)      mean <= MEAN_W'(MEAN_HI);
        else if (mean_sum < MEAN_LO) mean <= MEAN_W'(MEAN_LO);
        else                         mean <= MEAN_W'(mean_sum);
      end
      if (cmd.sds_upd) begin
        if (sds_sum > SDS_HI)      sds <= SDS_W'(SDS_HI);
        else if (sds_sum < SDS_LO) sds <= SDS_W'(SDS_LO);
        else                       sds <= SDS_W'(sds_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept)   x_reg <= signed'(in_sample);
    if (cmd.mean_upd) prev  <= mean;
    if (cmd.fac) begin
      ma    <= (mfa[DIFF_W-1:32] != '0) ? '1 : mfa[31:0];
      mb    <= (mfb[DIFF_W-1:32] != '0) ? '1 : mfb[31:0];
      psign <= fa[DIFF_W-1] ^ fb[DIFF_W-1];
    end
    if (cmd.mul)     prod  <= ma * mb;
    if (cmd.var_ld)  var_r <= (quot[NUM_W-1:RAD_W] != '0) ? '1 : quot[RAD_W-1:0];
    if (cmd.var_clr) var_r <= '0;
    if (cmd.z_ld) begin
      if (dz[DIFF_W-1])
        z_r <= (quot[NUM_W-1:21] != '0) ? 22'h200000 : 22'(-quot[21:0]);
      else
        z_r <= (quot[NUM_W-1:21] != '0) ? 22'h1FFFFF : quot[21:0];
    end
    if (cmd.z_clr) z_r <= '0;
    if (cmd.out_ld) begin
      out_data <= {5'b0, cnt_ext[WL_W-1:0], z_r, sd, var_r, mean_out, sum_out};
      out_flag <= (cnt_ext >= CMPW'(2));
    end
  end

  always_comb begin
    if (sum > SUM_HI)      sum_out = 26'h1FFFFFF;
    else if (sum < SUM_LO) sum_out = 26'h2000000;
    else                   sum_out = sum[25:0];
    if (mean[MEAN_W-1:31] == '0 || mean[MEAN_W-1:31] == '1) mean_out = mean[31:0];
    else if (mean[MEAN_W-1])                                  mean_out = 32'h80000000;
    else                                                      mean_out = 32'h7FFFFFFF;
  end

  assign st.removing  = removing;
  assign st.second    = second;
  assign st.var_ok    = (cnt_ext >= CMPW'(2)) && !sds[SDS_W-1] && (sds != '0);
  assign st.sd_nz     = (sd != '0);
  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;
  assign st.out_free  = !out_valid || out_ready;

endmodule

/* rtl/core/rolling_window_mean_variance.sv */
// ----------------------------------------------------------------------------
// rolling_window_mean_variance
// Sliding-window running sum, mean, variance, std deviation and z-score.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          sample
//  m_axis    out  tvalid/tready          sum, mean, var, std, z, count; tuser valid
//  cfg       in   cfg_we                 window_length
//
//  Each item passes from accept to result load through a mean division per
//  pass (a second pass drops the oldest sample), a variance division and a
//  z-score division (each skipped when it does not apply) and a square
//  root, all on the one shared serial divider and root unit.
//  A result waiting in the output register stalls only the final load.
//  Reset is synchronous; the window starts empty with length 1024.
// ----------------------------------------------------------------------------
module rolling_window_mean_variance #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rwmv_pkg::WL_W-1:0]             cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // window_sum[25:0] mean_value[57:26] variance[105:58] std_dev[129:106]
  // z_score[151:130] held_count[162:152]
  output logic [rwmv_pkg::OUT_W-1:0]            m_axis_tdata,
  // variance_valid
  output logic                                  m_axis_tuser
);
  import rwmv_pkg::*;

  rwmv_cmd_t  cmd;
  rwmv_stat_t st;

  rwmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rwmv_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .st        (st),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );

`include "rolling_window_mean_variance_assert.svh"

  // one item in flight: no accept directly after an accept
  `RWMV_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // with fewer than two samples, variance and z-score read zero
  `RWMV_ASSERT_NOW(a_var_zero, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[105:58] == '0) && (m_axis_tdata[151:130] == '0))
  // a result always reports at least the sample just pushed
  `RWMV_ASSERT_NOW(a_count_nz, m_axis_tvalid, m_axis_tdata[162:152] != '0)

endmodule

/* bench/rolling_window_mean_variance_test.sv */
// ----------------------------------------------------------------------------
// rolling_window_mean_variance_test
// Self-checking bench: drives samples over the stream input, predicts the
// sliding-window sum, mean, variance, std deviation and z-score per item and
// compares every output item field by field. Covers several window lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rolling_window_mean_variance_test;
  import rwmv_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int WDOG_LIMIT  = 200000;
  localparam int DRAIN_WAIT  = 800;

  typedef struct packed {
    logic        var_ok;
    logic [10:0] held;
    logic [21:0] z;
    logic [23:0] sd;
    logic [47:0] var_q;
    logic [31:0] mean;
    logic [25:0] sum;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [WL_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  rolling_window_mean_variance u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  // predictor state
  longint ring [RING_DEPTH];
  int     wr_ptr, held_n, win_len;
  longint sum_acc, mean_acc, sds_acc;

  stats_t expected_stats [$];
  int errors = 0, items_sent = 0, items_checked = 0, idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint dev_term(longint a, longint b);
    logic [63:0] ma, mb, p;
    ma = magn(a);
    mb = magn(b);
    if (ma > 64'hFFFFFFFF) ma = 64'hFFFFFFFF;
    if (mb > 64'hFFFFFFFF) mb = 64'hFFFFFFFF;
    p = (ma * mb) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void empty_window();
    wr_ptr = 0; held_n = 0; sum_acc = 0; mean_acc = 0; sds_acc = 0;
  endfunction

  function automatic stats_t window_update(logic [15:0] raw);
    stats_t r;
    longint x, xq, old, oq, prev, vq, d, z;
    logic [63:0] sd, q;
    int w;
    bit removing;
    w = win_len == 0 ? 1 : (win_len > RING_DEPTH ? RING_DEPTH : win_len);
    x = longint'($signed(raw));
    xq = x * 65536;
    vq = 0; z = 0; sd = 0; old = 0;
    removing = held_n >= w;
    if (removing) old = ring[(wr_ptr + RING_DEPTH - held_n) % RING_DEPTH];
    ring[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    held_n++;
    sum_acc += x;
    prev = mean_acc;
    mean_acc = clamp(mean_acc + (xq - mean_acc) / held_n, -(64'sd1 <<< 33), (64'sd1 <<< 33) - 1);
    sds_acc = clamp(sds_acc + dev_term(xq - mean_acc, xq - prev),
                    -(64'sd1 <<< 61), (64'sd1 <<< 61) - 1);
    if (removing) begin
      oq = old * 65536;
      held_n--;
      sum_acc -= old;
      prev = mean_acc;
      mean_acc = clamp(mean_acc - (oq - mean_acc) / held_n,
                       -(64'sd1 <<< 33), (64'sd1 <<< 33) - 1);
      sds_acc = clamp(sds_acc - dev_term(oq - mean_acc, oq - prev),
                      -(64'sd1 <<< 61), (64'sd1 <<< 61) - 1);
    end
    if (held_n >= 2 && sds_acc > 0) begin
      vq = sds_acc / (held_n - 1);
      if (vq > (64'sd1 <<< 48) - 1) vq = (64'sd1 <<< 48) - 1;
      sd = int_sqrt(vq);
    end
    if (sd != 0) begin
      d = xq - mean_acc;
      q = (64'(magn(d)) << 8) / sd;
      if (q > (64'd1 << 22)) q = 64'd1 << 22;
      z = d < 0 ? -longint'(q) : longint'(q);
      z = clamp(z, -(64'sd1 <<< 21), (64'sd1 <<< 21) - 1);
    end
    r.sum    = 26'(clamp(sum_acc, -(64'sd1 <<< 25), (64'sd1 <<< 25) - 1));
    r.mean   = 32'(clamp(mean_acc, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
    r.var_q  = 48'(vq);
    r.sd     = 24'(sd);
    r.z      = 22'(z);
    r.held   = 11'(held_n);
    r.var_ok = held_n >= 2;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at result %0d: got %h want %h", what, items_checked, got, want);
    errors++;
  endtask

  // random gap: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // tvalid stays up across a zero gap; callers drop it before idling
  task automatic send_sample(logic [15:0] v, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    expected_stats.push_back(window_update(v));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_window(int len);
    s_axis_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= WL_W'(len);
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_len = len;
    empty_window();
  endtask

  // output side: random stalls unless held off
  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[162:0]};
      if (expected_stats.size() == 0) begin
        $display("unexpected output item");
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (got.sum    != want.sum)    report_mismatch("window_sum", got.sum, want.sum);
        if (got.mean   != want.mean)   report_mismatch("mean_value", got.mean, want.mean);
        if (got.var_q  != want.var_q)  report_mismatch("variance", got.var_q, want.var_q);
        if (got.sd     != want.sd)     report_mismatch("std_dev", got.sd, want.sd);
        if (got.z      != want.z)      report_mismatch("z_score", got.z, want.z);
        if (got.held   != want.held)   report_mismatch("held_count", got.held, want.held);
        if (got.var_ok != want.var_ok) report_mismatch("variance_valid", got.var_ok, want.var_ok);
      end
      items_checked++;
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("[rolling_window_mean_variance] ERROR");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    logic [15:0] v [$];
    v = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFF,
          16'h8000, 16'h8000, 16'h5555, 16'hAAAA};
    send_sample(16'h1234); // single sample: variance invalid
    foreach (v[i]) send_sample(v[i]);
    write_window(3);
    repeat (5) send_sample(16'h0100); // constant: zero deviation
    repeat (4) send_sample(16'h8000);
    send_sample(16'h7FFF);
    write_window(0); // acts as one
    send_sample(16'h7FFF);
    send_sample(16'h8000);
  endtask

  task automatic test_window_above_max();
    write_window(2047);
    repeat (30) send_sample(16'($urandom));
  endtask

  task automatic test_backpressure();
    write_window(4);
    hold_off = 1'b1;
    fork
      begin
        repeat (12) send_sample(16'($urandom), 0);
      end
      begin
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic test_random_windows(int count);
    int lens [] = '{1, 2, 5, 17, 64, 1024, 300};
    int per;
    per = count / lens.size();
    foreach (lens[k]) begin
      write_window(lens[k]);
      for (int i = 0; i < per; i++) begin
        case ($urandom_range(0, 3))
          0: send_sample(16'($urandom));
          1: send_sample(16'($urandom_range(0, 255)) - 16'd128);
          2: send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
          default: send_sample(16'(16'sd1000 + $signed(16'($urandom_range(0, 15)))));
        endcase
      end
    end
  endtask

  initial begin
    win_len = 1024;
    empty_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_window_above_max();
    test_backpressure();
    test_random_windows(1700);
    s_axis_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d samples, checked %0d results over window lengths 0..2047",
             items_sent, items_checked);
    $display("including extremes, constant runs and a long output stall");
    if (errors == 0) $display("[rolling_window_mean_variance] OK");
    else $display("[rolling_window_mean_variance] ERROR");
    $finish;
  end
endmodule

/* rolling_window_mean_variance.f */
+incdir+rtl/core
rtl/core/rwmv_pkg.sv
rtl/core/rwmv_div.sv
rtl/core/rwmv_sqrt.sv
rtl/core/rwmv_ctrl.sv
rtl/core/rwmv_dp.sv
rtl/core/rolling_window_mean_variance.sv
bench/rolling_window_mean_variance_test.sv
